// File: rtl/rstoi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and widths for the radix string-to-integer block.
// Used by every other file of the block; depends on nothing.
package rstoi_pkg;

	localparam int MAX_SYMBOLS = 16;
	localparam int SYM_W       = 8;
	localparam int DIGIT_W     = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int RADIX_W     = 5;
	localparam int VALUE_W     = 32;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 2) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd2;

	localparam logic [CFG_W-1:0]   SYMBOLS_LOW_RST  = 64'h0000_0000_0000_3130;
	localparam logic [CFG_W-1:0]   SYMBOLS_HIGH_RST = 64'h0;
	localparam logic [RADIX_W-1:0] RADIX_RST        = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MIN        = 5'd2;

	localparam logic [SYM_W-1:0] CH_NUL      = 8'd0;
	localparam logic [SYM_W-1:0] CH_TAB      = 8'd9;
	localparam logic [SYM_W-1:0] CH_CR       = 8'd13;
	localparam logic [SYM_W-1:0] CH_SPACE    = 8'd32;
	localparam logic [SYM_W-1:0] CH_PLUS     = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS    = 8'h2D;
	localparam logic [SYM_W-1:0] CH_PRINT_LO = 8'd32;
	localparam logic [SYM_W-1:0] CH_PRINT_HI = 8'd126;

	typedef enum logic [1:0] {
		PH_WS    = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [MAX_SYMBOLS-1:0][SYM_W-1:0] symbols;
		logic [RADIX_W-1:0]                radix;
		logic                              alphabet_ok;
	} cfg_t;

	typedef struct packed {
		logic               first;
		logic               ws;
		logic               plus;
		logic               minus;
		logic               hit;
		logic [DIGIT_W-1:0] digit;
	} class_t;

endpackage

// File: rtl/rstoi_in_if.sv
`timescale 1ns / 1ps
// Character channel: valid/ready handshake carrying one character and its first flag.
// Depends on rstoi_pkg.
interface rstoi_in_if;
	logic                          valid;
	logic                          ready;
	logic [rstoi_pkg::SYM_W-1:0]   ch;
	logic                          first;

	modport source(output valid, output ch, output first, input ready);
	modport sink(input valid, input ch, input first, output ready);
endinterface

// File: rtl/rstoi_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying the converted value and base_ok.
// Depends on rstoi_pkg.
interface rstoi_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [rstoi_pkg::VALUE_W-1:0] value;
	logic                                base_ok;

	modport source(output valid, output value, output base_ok, input ready);
	modport sink(input valid, input value, input base_ok, output ready);
endinterface

// File: rtl/radix_string_to_int.sv
`timescale 1ns / 1ps
// Top level of the radix string-to-integer converter.
// Depends on rstoi_pkg, rstoi_in_if, rstoi_out_if, rstoi_cfg, rstoi_front, rstoi_fifo, rstoi_back.
//
// Usage: characters arrive on the chars channel, one item per character, with
// first set on the first character of each string. Leading whitespace is
// skipped, a run of plus and minus signs sets the sign, and symbols of the
// configured alphabet are accumulated as digits. The first other character, or
// a zero byte, makes one result item on the results channel; later characters
// are dropped until the next first flag. An invalid alphabet gives value 0 with
// base_ok low. The alphabet and radix are to be written through wr_en, wr_idx
// and wr_data only while the block is idle; the block itself does not enforce
// this. The validity check is registered and follows a write in the next cycle.
// Throughput is one character per cycle while the queue is not full. An accepted
// character is written into the classified-character queue, and the parser takes
// it into the result register, where results.valid is raised when it ends a string.
// When results.ready is low and a result is waiting, the result register holds and
// the parser stops; the two-entry queue keeps accepting characters until it is full.
// Reset restores the alphabet "01" with radix 2, empties the queue and leaves
// the parser waiting for a first flag.
module radix_string_to_int (
	input  logic                             clk,
	input  logic                             arst_n,
	rstoi_in_if.sink                         chars,
	rstoi_out_if.source                      results,
	input  logic                             wr_en,
	input  logic [rstoi_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  logic [rstoi_pkg::CFG_W-1:0]      wr_data
);

	rstoi_pkg::cfg_t   cfg;
	rstoi_pkg::class_t cls;
	rstoi_pkg::class_t head;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;

	rstoi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.cfg     (cfg)
	);

	rstoi_front u_front (
		.chars  (chars),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.cls    (cls)
	);

	rstoi_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.pop    (pop),
		.rdata  (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	rstoi_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.e       (head),
		.q_empty (q_empty),
		.pop     (pop),
		.results (results)
	);

endmodule

// File: rtl/rstoi_cfg.sv
`timescale 1ns / 1ps
// Configuration registers and the registered alphabet validity check.
// Depends on rstoi_pkg.
module rstoi_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [rstoi_pkg::CFG_IDX_W-1:0]   wr_idx,
	input  logic [rstoi_pkg::CFG_W-1:0]       wr_data,
	output rstoi_pkg::cfg_t                   cfg
);

	logic [rstoi_pkg::CFG_W-1:0]   sym_low_q;
	logic [rstoi_pkg::CFG_W-1:0]   sym_high_q;
	logic [rstoi_pkg::RADIX_W-1:0] radix_q;
	logic                          alphabet_ok_q;
	logic [2*rstoi_pkg::CFG_W-1:0] sym_all;
	logic [rstoi_pkg::MAX_SYMBOLS-1:0][rstoi_pkg::SYM_W-1:0] syms;
	logic                          ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_low_q  <= rstoi_pkg::SYMBOLS_LOW_RST;
			sym_high_q <= rstoi_pkg::SYMBOLS_HIGH_RST;
			radix_q    <= rstoi_pkg::RADIX_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				rstoi_pkg::REG_SYMBOLS_LOW:  sym_low_q  <= wr_data;
				rstoi_pkg::REG_SYMBOLS_HIGH: sym_high_q <= wr_data;
				rstoi_pkg::REG_RADIX:        radix_q    <= wr_data[rstoi_pkg::RADIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign sym_all = {sym_high_q, sym_low_q};

	always_comb begin
		for (int k = 0; k < rstoi_pkg::MAX_SYMBOLS; k++) begin
			syms[k] = sym_all[k*rstoi_pkg::SYM_W +: rstoi_pkg::SYM_W];
		end
	end

	always_comb begin
		ok = (radix_q >= rstoi_pkg::RADIX_MIN) &&
			(radix_q <= rstoi_pkg::RADIX_W'(rstoi_pkg::MAX_SYMBOLS));
		for (int a = 0; a < rstoi_pkg::MAX_SYMBOLS; a++) begin
			if (rstoi_pkg::RADIX_W'(a) < radix_q) begin
				if (syms[a] < rstoi_pkg::CH_PRINT_LO || syms[a] > rstoi_pkg::CH_PRINT_HI ||
					syms[a] == rstoi_pkg::CH_PLUS || syms[a] == rstoi_pkg::CH_MINUS) begin
					ok = 1'b0;
				end
				for (int b = a + 1; b < rstoi_pkg::MAX_SYMBOLS; b++) begin
					if (rstoi_pkg::RADIX_W'(b) < radix_q && syms[b] == syms[a]) begin
						ok = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_ok_q <= 1'b1;
		end else begin
			alphabet_ok_q <= ok;
		end
	end

	assign cfg.symbols     = syms;
	assign cfg.radix       = radix_q;
	assign cfg.alphabet_ok = alphabet_ok_q;

endmodule

// File: rtl/rstoi_front.sv
`timescale 1ns / 1ps
// Front end: accepts characters and classifies them (whitespace, sign, digit lookup).
// Depends on rstoi_pkg and rstoi_in_if.
module rstoi_front (
	rstoi_in_if.sink        chars,
	input  rstoi_pkg::cfg_t cfg,
	input  logic            q_full,
	output logic            push,
	output rstoi_pkg::class_t cls
);

	assign chars.ready = !q_full;
	assign push        = chars.valid && !q_full;

	always_comb begin
		cls.first = chars.first;
		cls.ws    = (chars.ch == rstoi_pkg::CH_SPACE) ||
			(chars.ch >= rstoi_pkg::CH_TAB && chars.ch <= rstoi_pkg::CH_CR);
		cls.plus  = (chars.ch == rstoi_pkg::CH_PLUS);
		cls.minus = (chars.ch == rstoi_pkg::CH_MINUS);
		cls.hit   = 1'b0;
		cls.digit = '0;
		// Lowest matching position wins.
		for (int k = rstoi_pkg::MAX_SYMBOLS - 1; k >= 0; k--) begin
			if (rstoi_pkg::RADIX_W'(k) < cfg.radix && cfg.symbols[k] == chars.ch) begin
				cls.hit   = 1'b1;
				cls.digit = rstoi_pkg::DIGIT_W'(k);
			end
		end
		if (chars.ch == rstoi_pkg::CH_NUL) begin
			cls.hit = 1'b0;
		end
	end

endmodule

// File: rtl/rstoi_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified characters between the front and back ends.
// Depends on rstoi_pkg.
module rstoi_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rstoi_pkg::class_t wdata,
	input  logic              pop,
	output rstoi_pkg::class_t rdata,
	output logic              full,
	output logic              empty
);

	rstoi_pkg::class_t               mem_q [rstoi_pkg::QDEPTH];
	logic [rstoi_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [rstoi_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [rstoi_pkg::QCNT_W-1:0]    count_q;

	function automatic logic [rstoi_pkg::QPTR_W-1:0] ptr_inc(
		input logic [rstoi_pkg::QPTR_W-1:0] p);
		return (p == rstoi_pkg::QPTR_W'(rstoi_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = (count_q == rstoi_pkg::QCNT_W'(rstoi_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rstoi_pkg::QCNT_W'(rstoi_pkg::QDEPTH))
		else $error("queue count above depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |-> !push)
		else $error("push into full queue");

endmodule

// File: rtl/rstoi_back.sv
`timescale 1ns / 1ps
// Back end: parser state, digit accumulation and the registered result stage.
// Depends on rstoi_pkg and rstoi_out_if.
module rstoi_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rstoi_pkg::cfg_t   cfg,
	input  rstoi_pkg::class_t e,
	input  logic              q_empty,
	output logic              pop,
	rstoi_out_if.source       results
);

	rstoi_pkg::phase_t                 phase_q;
	logic                              neg_q;
	logic [rstoi_pkg::VALUE_W-1:0]     accum_q;
	logic                              res_valid_q;
	logic [rstoi_pkg::VALUE_W-1:0]     value_q;
	logic                              base_ok_q;

	rstoi_pkg::phase_t                 ph;
	rstoi_pkg::phase_t                 ph_n;
	logic                              ng;
	logic                              ng_n;
	logic [rstoi_pkg::VALUE_W-1:0]     ac;
	logic [rstoi_pkg::VALUE_W-1:0]     ac_n;
	logic [rstoi_pkg::VALUE_W-1:0]     mul;
	logic                              emit;
	logic                              emit_ok;
	logic [rstoi_pkg::VALUE_W-1:0]     emit_val;

	assign pop = !q_empty && (!res_valid_q || results.ready);

	assign mul = ac * rstoi_pkg::VALUE_W'(cfg.radix);

	always_comb begin
		ph       = e.first ? rstoi_pkg::PH_WS : phase_q;
		ng       = e.first ? 1'b0 : neg_q;
		ac       = e.first ? '0 : accum_q;
		ph_n     = ph;
		ng_n     = ng;
		ac_n     = ac;
		emit     = 1'b0;
		emit_ok  = 1'b0;
		emit_val = '0;
		if (ph != rstoi_pkg::PH_DONE) begin
			if (!cfg.alphabet_ok) begin
				ph_n = rstoi_pkg::PH_DONE;
				emit = 1'b1;
			end else if (!(ph == rstoi_pkg::PH_WS && e.ws)) begin
				priority if ((ph == rstoi_pkg::PH_WS || ph == rstoi_pkg::PH_SIGN) &&
					(e.plus || e.minus)) begin
					ph_n = rstoi_pkg::PH_SIGN;
					ng_n = ng ^ e.minus;
				end else if (e.hit) begin
					ph_n = rstoi_pkg::PH_DIGIT;
					ac_n = mul + rstoi_pkg::VALUE_W'(e.digit);
				end else begin
					ph_n     = rstoi_pkg::PH_DONE;
					emit     = 1'b1;
					emit_ok  = 1'b1;
					emit_val = ng ? (rstoi_pkg::VALUE_W'(0) - ac) : ac;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= rstoi_pkg::PH_DONE;
			neg_q       <= 1'b0;
			accum_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= ph_n;
				neg_q   <= ng_n;
				accum_q <= ac_n;
			end
			if (pop && emit) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			value_q   <= emit_val;
			base_ok_q <= emit_ok;
		end
	end

	assign results.valid   = res_valid_q;
	assign results.value   = value_q;
	assign results.base_ok = base_ok_q;

	a_bad_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !base_ok_q) |-> (value_q == '0))
		else $error("invalid alphabet result with nonzero value");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (phase_q == rstoi_pkg::PH_DONE))
		else $error("parser not done after a result");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !results.ready) |-> !pop)
		else $error("queue popped while result stalled");

endmodule

// File: test/radix_string_to_int_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_string_to_int: drives strings under many alphabets and
// compares every result item with a cycle-free predictor. Depends on rstoi_pkg, rstoi_in_if,
// rstoi_out_if and the RTL of the block.
module radix_string_to_int_tb;

	localparam int NUM_SETTINGS = 25;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;

	typedef struct {
		logic signed [rstoi_pkg::VALUE_W-1:0] value;
		logic                                 base_ok;
	} conversion_t;

	class radix_scoreboard;
		logic [rstoi_pkg::MAX_SYMBOLS-1:0][rstoi_pkg::SYM_W-1:0] symbols;
		logic [rstoi_pkg::RADIX_W-1:0]                           radix;
		rstoi_pkg::phase_t                                       parse_phase;
		logic                                                    negative;
		logic [rstoi_pkg::VALUE_W-1:0]                           accum;
		conversion_t                                             expected_values[$];
		int                                                      fail_count;
		int                                                      values_checked;
		int                                                      invalid_values;

		function new();
			symbols = {rstoi_pkg::SYMBOLS_HIGH_RST, rstoi_pkg::SYMBOLS_LOW_RST};
			radix = rstoi_pkg::RADIX_RST;
			parse_phase = rstoi_pkg::PH_DONE;
			negative = 1'b0;
			accum = '0;
			fail_count = 0;
			values_checked = 0;
			invalid_values = 0;
		endfunction

		function void set_alphabet(logic [2*rstoi_pkg::CFG_W-1:0] syms,
			logic [rstoi_pkg::RADIX_W-1:0] r);
			symbols = syms;
			radix = r;
		endfunction

		function bit alphabet_ok();
			int a;
			int b;
			if (radix < rstoi_pkg::RADIX_MIN || radix > rstoi_pkg::MAX_SYMBOLS)
				return 1'b0;
			for (a = 0; a < radix; a++) begin
				if (symbols[a] < rstoi_pkg::CH_PRINT_LO || symbols[a] > rstoi_pkg::CH_PRINT_HI ||
				    symbols[a] == rstoi_pkg::CH_PLUS || symbols[a] == rstoi_pkg::CH_MINUS)
					return 1'b0;
				for (b = a + 1; b < radix; b++)
					if (symbols[b] == symbols[a])
						return 1'b0;
			end
			return 1'b1;
		endfunction

		function int digit_of(logic [rstoi_pkg::SYM_W-1:0] c);
			int k;
			for (k = 0; k < radix && k < rstoi_pkg::MAX_SYMBOLS; k++)
				if (symbols[k] == c)
					return k;
			return -1;
		endfunction

		function void report(string msg);
			fail_count++;
			if (fail_count <= 10)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endfunction

		function void note_char(logic [rstoi_pkg::SYM_W-1:0] c, logic first);
			conversion_t res;
			int d;
			if (first) begin
				parse_phase = rstoi_pkg::PH_WS;
				negative = 1'b0;
				accum = '0;
			end
			if (parse_phase == rstoi_pkg::PH_DONE)
				return;
			if (!alphabet_ok()) begin
				parse_phase = rstoi_pkg::PH_DONE;
				res.value = '0;
				res.base_ok = 1'b0;
				expected_values.push_back(res);
				return;
			end
			if (parse_phase == rstoi_pkg::PH_WS) begin
				if (c == rstoi_pkg::CH_SPACE || (c >= rstoi_pkg::CH_TAB && c <= rstoi_pkg::CH_CR))
					return;
				parse_phase = rstoi_pkg::PH_SIGN;
			end
			if (parse_phase == rstoi_pkg::PH_SIGN) begin
				if (c == rstoi_pkg::CH_PLUS || c == rstoi_pkg::CH_MINUS) begin
					if (c == rstoi_pkg::CH_MINUS)
						negative = ~negative;
					return;
				end
				parse_phase = rstoi_pkg::PH_DIGIT;
			end
			d = (c == rstoi_pkg::CH_NUL) ? -1 : digit_of(c);
			if (d >= 0) begin
				accum = accum * rstoi_pkg::VALUE_W'(radix) + rstoi_pkg::VALUE_W'(d);
				return;
			end
			parse_phase = rstoi_pkg::PH_DONE;
			res.value = negative ? (rstoi_pkg::VALUE_W'(0) - accum) : accum;
			res.base_ok = 1'b1;
			expected_values.push_back(res);
		endfunction

		function void check_value(logic signed [rstoi_pkg::VALUE_W-1:0] value, logic base_ok);
			conversion_t want;
			values_checked++;
			if (base_ok !== 1'b1)
				invalid_values++;
			if (expected_values.size() == 0) begin
				report($sformatf("unexpected item value=%0d base_ok=%0b", value, base_ok));
				return;
			end
			want = expected_values.pop_front();
			if (value !== want.value)
				report($sformatf("value expected %0d got %0d", want.value, value));
			if (base_ok !== want.base_ok)
				report($sformatf("base_ok expected %0b got %0b", want.base_ok, base_ok));
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            wr_en;
	logic [rstoi_pkg::CFG_IDX_W-1:0] wr_idx;
	logic [rstoi_pkg::CFG_W-1:0]     wr_data;

	rstoi_in_if  chars_if();
	rstoi_out_if results_if();

	radix_scoreboard board;
	int              src_idle_pct;
	int              sink_stall_pct;
	int              chars_sent;
	int              settings_used;
	int              quiet_cycles = 0;

	radix_string_to_int dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		results_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		if (arst_n && chars_if.valid && chars_if.ready)
			board.note_char(chars_if.ch, chars_if.first);
		if (arst_n && results_if.valid && results_if.ready)
			board.check_value(results_if.value, results_if.base_ok);
	end

	always @(posedge clk) begin
		if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [2*rstoi_pkg::CFG_W-1:0] pack_symbols(string s);
		logic [2*rstoi_pkg::CFG_W-1:0] w;
		int i;
		w = '0;
		for (i = 0; i < s.len() && i < rstoi_pkg::MAX_SYMBOLS; i++)
			w[i*rstoi_pkg::SYM_W +: rstoi_pkg::SYM_W] = s[i];
		return w;
	endfunction

	task automatic send_char(logic [rstoi_pkg::SYM_W-1:0] c, logic first);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			chars_if.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch <= c;
		chars_if.first <= first;
		do
			@(posedge clk);
		while (!chars_if.ready);
		chars_sent++;
	endtask

	task automatic wait_idle();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (board.expected_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_alphabet(logic [2*rstoi_pkg::CFG_W-1:0] syms,
		logic [rstoi_pkg::RADIX_W-1:0] r);
		logic [rstoi_pkg::CFG_W-1:0] radix_word;
		radix_word = {$urandom(), $urandom()};
		if ($urandom_range(0, 1))
			radix_word = '0;
		radix_word[rstoi_pkg::RADIX_W-1:0] = r;
		wait_idle();
		wr_en <= 1'b1;
		wr_idx <= rstoi_pkg::REG_SYMBOLS_LOW;
		wr_data <= syms[rstoi_pkg::CFG_W-1:0];
		@(posedge clk);
		wr_idx <= rstoi_pkg::REG_SYMBOLS_HIGH;
		wr_data <= syms[2*rstoi_pkg::CFG_W-1:rstoi_pkg::CFG_W];
		@(posedge clk);
		wr_idx <= rstoi_pkg::REG_RADIX;
		wr_data <= radix_word;
		@(posedge clk);
		wr_en <= 1'b0;
		board.set_alphabet(syms, r);
		repeat (2) @(posedge clk);
	endtask

	task automatic send_string();
		logic [rstoi_pkg::SYM_W-1:0] text[$];
		logic [rstoi_pkg::SYM_W-1:0] c;
		int                          n;
		int                          i;
		int                          pick;
		repeat ($urandom_range(0, 3)) begin
			pick = $urandom_range(0, 6);
			text.push_back((pick == 6) ? rstoi_pkg::CH_SPACE :
				rstoi_pkg::CH_TAB + rstoi_pkg::SYM_W'(pick));
		end
		repeat ($urandom_range(0, 3))
			text.push_back($urandom_range(0, 1) ? rstoi_pkg::CH_MINUS : rstoi_pkg::CH_PLUS);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
		repeat (n) begin
			if (board.alphabet_ok())
				text.push_back(board.symbols[$urandom_range(0, board.radix - 1)]);
			else
				text.push_back(rstoi_pkg::SYM_W'($urandom_range(0, 255)));
		end
		pick = $urandom_range(0, 9);
		if (pick < 5 || (pick == 9 && text.size() == 0)) begin
			text.push_back(rstoi_pkg::CH_NUL);
		end else if (pick < 9) begin
			do
				c = rstoi_pkg::SYM_W'($urandom_range(0, 255));
			while (board.digit_of(c) >= 0);
			text.push_back(c);
		end
		repeat ($urandom_range(0, 2))
			text.push_back(rstoi_pkg::SYM_W'($urandom_range(0, 255)));
		for (i = 0; i < text.size(); i++)
			send_char(text[i], i == 0);
	endtask

	initial begin
		int                            p;
		int                            phase_start;
		int                            budget;
		int                            k;
		int                            j;
		bit                            paused;
		bit                            taken;
		logic [2*rstoi_pkg::CFG_W-1:0] syms;
		logic [rstoi_pkg::RADIX_W-1:0] r;
		logic [rstoi_pkg::SYM_W-1:0]   c;

		board = new();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		chars_sent = 0;
		settings_used = 0;
		arst_n <= 1'b0;
		chars_if.valid <= 1'b0;
		chars_if.ch <= rstoi_pkg::CH_NUL;
		chars_if.first <= 1'b0;
		wr_en <= 1'b0;
		wr_idx <= rstoi_pkg::REG_SYMBOLS_LOW;
		wr_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset alphabet "01": a character before any first flag is dropped.
		send_char("1", 1'b0);
		send_char(rstoi_pkg::CH_SPACE, 1'b1);
		send_char(rstoi_pkg::CH_TAB, 1'b0);
		send_char(rstoi_pkg::CH_CR, 1'b0);
		send_char(rstoi_pkg::CH_PLUS, 1'b0);
		send_char(rstoi_pkg::CH_MINUS, 1'b0);
		send_char(rstoi_pkg::CH_MINUS, 1'b0);
		send_char(rstoi_pkg::CH_MINUS, 1'b0);
		send_char("1", 1'b0);
		send_char("0", 1'b0);
		send_char("1", 1'b0);
		send_char(rstoi_pkg::CH_NUL, 1'b0);
		send_char("x", 1'b0);
		send_char("1", 1'b1);
		send_char("1", 1'b0);
		send_char("2", 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(rstoi_pkg::CH_NUL, 1'b1);
		send_char(rstoi_pkg::CH_MINUS, 1'b1);
		send_char(rstoi_pkg::CH_NUL, 1'b0);
		send_char(8'd8, 1'b1);
		send_char(8'd14, 1'b1);

		for (p = 0; p < NUM_SETTINGS; p++) begin
			syms = pack_symbols("0123456789ABCDEF");
			r = 5'd16;
			case (p)
				0: ;
				1: write_alphabet(pack_symbols("0123456789"), 5'd10);
				2: write_alphabet(syms, 5'd16);
				3: write_alphabet(pack_symbols(" ~!*az,.ZA9/:;<@"), 5'd16);
				4: write_alphabet(pack_symbols("zy"), 5'd2);
				5: write_alphabet(pack_symbols("0"), 5'd1);
				6: write_alphabet('0, 5'd0);
				7: write_alphabet(syms, 5'd17);
				8: write_alphabet(syms, 5'd31);
				9: write_alphabet(pack_symbols("0120"), 5'd4);
				10: write_alphabet(pack_symbols("01+"), 5'd3);
				11: write_alphabet(pack_symbols("-01"), 5'd3);
				12: begin
					syms = pack_symbols("0a");
					syms[2*rstoi_pkg::SYM_W-1:rstoi_pkg::SYM_W] = 8'd31;
					write_alphabet(syms, 5'd2);
				end
				13: begin
					syms[2*rstoi_pkg::CFG_W-1 -: rstoi_pkg::SYM_W] = 8'd127;
					write_alphabet(syms, 5'd16);
				end
				14: write_alphabet(pack_symbols("abcaa++-"), 5'd3);
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						syms = {$urandom(), $urandom(), $urandom(), $urandom()};
						r = rstoi_pkg::RADIX_W'($urandom_range(0, 31));
					end else begin
						syms = '0;
						r = rstoi_pkg::RADIX_W'($urandom_range(2, rstoi_pkg::MAX_SYMBOLS));
						for (k = 0; k < rstoi_pkg::MAX_SYMBOLS; k++) begin
							do begin
								c = rstoi_pkg::SYM_W'($urandom_range(rstoi_pkg::CH_PRINT_LO,
									rstoi_pkg::CH_PRINT_HI));
								taken = (c == rstoi_pkg::CH_PLUS || c == rstoi_pkg::CH_MINUS);
								for (j = 0; j < k; j++)
									if (syms[j*rstoi_pkg::SYM_W +: rstoi_pkg::SYM_W] == c)
										taken = 1'b1;
							end while (taken);
							syms[k*rstoi_pkg::SYM_W +: rstoi_pkg::SYM_W] = c;
						end
					end
					write_alphabet(syms, r);
				end
			endcase
			settings_used++;

			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
				default: begin src_idle_pct = 17; sink_stall_pct = 17; end
			endcase

			// A string left open before the alphabet change may continue here.
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 3))
					send_char(rstoi_pkg::SYM_W'($urandom_range(0, 255)), 1'b0);

			phase_start = chars_sent;
			budget = board.alphabet_ok() ? 60 : 25;
			paused = 1'b0;
			while (chars_sent - phase_start < budget) begin
				if ($urandom_range(0, 99) < 85)
					send_string();
				else
					repeat ($urandom_range(1, 6))
						send_char(rstoi_pkg::SYM_W'($urandom_range(0, 255)),
							$urandom_range(0, 3) == 0);
				if (!paused && chars_sent - phase_start >= budget / 2) begin
					paused = 1'b1;
					chars_if.valid <= 1'b0;
					@(posedge clk);
					while (board.expected_values.size() != 0)
						@(posedge clk);
				end
			end
		end

		wait_idle();
		if (board.expected_values.size() != 0)
			board.report($sformatf("%0d expected items never arrived",
				board.expected_values.size()));
		$display("Sent %0d characters under %0d alphabet settings, including invalid ones.",
			chars_sent, settings_used);
		$display("Checked %0d result items, %0d of them with base_ok low; %0d failures.",
			board.values_checked, board.invalid_values, board.fail_count);
		if (board.fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// File: sim.f
rtl/rstoi_pkg.sv
rtl/rstoi_in_if.sv
rtl/rstoi_out_if.sv
rtl/rstoi_cfg.sv
rtl/rstoi_front.sv
rtl/rstoi_fifo.sv
rtl/rstoi_back.sv
rtl/radix_string_to_int.sv
test/radix_string_to_int_tb.sv
